FILE: src/drt_pkg.sv
// Package for the drip-rate remaining-time estimator.
// Holds widths, request and register codes, and the cell control type.
// No dependencies; every other file imports it.
package drt_pkg;

  // Window geometry
  localparam int WINDOW_LEN = 10;
  localparam int DATA_W     = 16;
  // Pair counter: holds up to WINDOW_LEN - 1, also used as the scan index
  localparam int CNT_W      = $clog2(WINDOW_LEN);
  localparam int SUM_W      = DATA_W + CNT_W;
  localparam int NUM_W      = DATA_W + CNT_W;

  // Result field widths
  localparam int TICKS_W    = 20;
  localparam int DSUM_W     = 20;
  localparam int DCNT_W     = 4;
  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  // Stream packing
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - TICKS_W - DSUM_W - DCNT_W;

  // Request kinds carried on s_tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Configuration register indexes
  localparam int   CFG_IDX_W        = 1;
  localparam logic CFG_EMPTY_WEIGHT = 1'b0;
  localparam logic CFG_MAX_WEIGHT   = 1'b1;

  // Control shared by all window cells
  typedef struct packed {
    logic clr;   // zero the cell
    logic step;  // take the neighbor's value
  } cell_ctrl_t;

endpackage

FILE: src/drt_cell.sv
// One window cell: holds a single weight sample.
// On step it takes the value handed over by its newer neighbor.
// Depends on drt_pkg.
module drt_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  drt_pkg::cell_ctrl_t     ctrl,
  input  logic [drt_pkg::DATA_W-1:0] din,
  output logic [drt_pkg::DATA_W-1:0] dout
);
  import drt_pkg::*;

  logic [DATA_W-1:0] sample;

  // Clear or advance the held sample
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      sample <= '0;
    end else if (ctrl.step) begin
      sample <= din;
    end
  end

  assign dout = sample;

endmodule

FILE: src/drt_div.sv
// Restoring divider for the remaining-time estimate, one quotient bit per cycle.
// Done pulses for one cycle with the quotient once all NUM_W bits are in.
// Depends on drt_pkg.
module drt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [drt_pkg::NUM_W-1:0] num,
  input  logic [drt_pkg::SUM_W-1:0] den,
  output logic                      done,
  output logic [drt_pkg::NUM_W-1:0] quo
);
  import drt_pkg::*;

  localparam int BITS_W = $clog2(NUM_W + 1);

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  divisor;
  logic [NUM_W-1:0]  shreg;
  logic [BITS_W-1:0] bits_left;
  logic              busy;
  logic [SUM_W:0]    trial;
  logic              fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem, shreg[NUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        bits_left <= BITS_W'(NUM_W);
      end else if (busy) begin
        bits_left <= bits_left - 1'b1;
        if (bits_left == BITS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top, quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= den;
      shreg   <= num;
    end else if (busy) begin
      if (fits) begin
        rem   <= SUM_W'(trial - {1'b0, divisor});
        shreg <= {shreg[NUM_W-2:0], 1'b1};
      end else begin
        rem   <= trial[SUM_W-1:0];
        shreg <= {shreg[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = shreg;

endmodule

FILE: src/drip_rate_remaining_time_top.sv
// Top level of the drip-rate remaining-time estimator.
// Uses drt_pkg, a row of drt_cell window cells and the drt_div serial divider.
//
//  Port group    Role     Payload (low bit first)
//  s_*           input    tdata: weight[15:0]; tuser: req_type
//  m_*           output   tdata: remaining_ticks, drop_sum, drop_count, pad;
//                         tuser: stopped
//  cfg_*         config   cfg_index: register; cfg_data: value
//
// A clear or out-of-range sample goes from idle straight to the emit step,
// which raises m_tvalid once the output register is free. An in-range sample
// rotates the window cells past the pair compare in the scan step, then
// passes the scale step, the divider and the emit step; with no counted
// pairs or a zero drop sum the divider is skipped. Synchronous reset (rst)
// zeroes the window, countdown and empty weight; max weight goes to all ones.
// A result waiting on m_tready holds the block in its emit step; a new item
// is accepted as soon as the previous result is in the output register.
module drip_rate_remaining_time_top (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [drt_pkg::IN_TDATA_W-1:0]    s_tdata,   // weight[15:0]
  input  logic                              s_tuser,   // req_type
  // Output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // remaining_ticks[19:0], drop_sum[39:20], drop_count[43:40], zero pad[47:44]
  output logic [drt_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tuser,   // stopped
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drt_pkg::DATA_W-1:0]        cfg_data
);
  import drt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [DATA_W-1:0]   tare_weight;
  logic [DATA_W-1:0]   max_weight;
  logic [TICKS_W-1:0]  countdown;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    scan_idx;
  logic [DATA_W-1:0]   excess;
  logic                stopped;

  logic                accept;
  logic                in_range;
  logic                out_free;
  cell_ctrl_t          cell_ctrl;
  logic [DATA_W-1:0]   cell_in  [WINDOW_LEN];
  logic [DATA_W-1:0]   cell_out [WINDOW_LEN];
  logic                div_start;
  logic                div_done;
  logic [NUM_W-1:0]    div_num;
  logic [NUM_W-1:0]    div_quo;
  logic [DATA_W-1:0]   pair_drop;
  logic                pair_ok;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign in_range  = (s_tdata > tare_weight) && (s_tdata < max_weight);
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tare_weight <= '0;
      max_weight  <= {DATA_W{1'b1}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EMPTY_WEIGHT: tare_weight <= cfg_data;
        CFG_MAX_WEIGHT:   max_weight  <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Window control: clear on a clear request, shift a new sample in, or rotate during the scan
  always_comb begin
    cell_ctrl.clr  = accept && (s_tuser == REQ_CLEAR);
    cell_ctrl.step = (accept && (s_tuser == REQ_SAMPLE) && in_range) ||
                     (state == ST_SCAN);
  end

  // Newest sample enters the top cell; the scan feeds the oldest back around
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
      if (gi == WINDOW_LEN - 1) begin : g_top
        assign cell_in[gi] = (state == ST_SCAN) ? cell_out[0] : s_tdata;
      end else begin : g_mid
        assign cell_in[gi] = cell_out[gi+1];
      end
      drt_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cell_ctrl),
        .din  (cell_in[gi]),
        .dout (cell_out[gi])
      );
    end
  endgenerate

  // Pair at the bottom of the window: older in cell 0, newer in cell 1
  assign pair_ok   = (cell_out[0] >= cell_out[1]) &&
                     (scan_idx != CNT_W'(WINDOW_LEN - 1));
  assign pair_drop = cell_out[0] - cell_out[1];

  // Scale the excess weight by the pair count and divide by the drop sum
  assign div_num   = NUM_W'(excess) * NUM_W'(cnt);
  assign div_start = (state == ST_SCALE) && (cnt != '0) && (sum != '0);

  drt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      countdown <= '0;
      sum       <= '0;
      cnt       <= '0;
      scan_idx  <= '0;
      stopped   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // Raise valid when a result is loaded, drop it once taken
      if ((state == ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sum      <= '0;
            cnt      <= '0;
            scan_idx <= '0;
            stopped  <= 1'b0;
            excess   <= s_tdata - tare_weight;
            if (s_tuser == REQ_CLEAR) begin
              countdown <= '0;
              state     <= ST_EMIT;
            end else if (in_range) begin
              state <= ST_SCAN;
            end else begin
              if (countdown != '0) begin
                countdown <= countdown - 1'b1;
              end else begin
                stopped <= 1'b1;
              end
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          if (pair_ok) begin
            sum <= sum + SUM_W'(pair_drop);
            cnt <= cnt + 1'b1;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == CNT_W'(WINDOW_LEN - 1)) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= div_start ? ST_DIVIDE : ST_EMIT;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            if (32'(div_quo) > 32'(TICKS_MAX)) begin
              countdown <= TICKS_MAX;
            end else begin
              countdown <= TICKS_W'(div_quo);
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tdata  <= {{OUT_PAD_W{1'b0}}, DCNT_W'(cnt), DSUM_W'(sum), countdown};
            m_tuser  <= stopped;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/drt_checker.sv
// Port-level checker for the drip-rate remaining-time estimator.
// Sees only the top-level ports; bound to drip_rate_remaining_time_top below.
// Depends on drt_pkg for widths.
module drt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [drt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import drt_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // Stopped only when the countdown is exhausted
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[TICKS_W-1:0] == '0)
    else $error("stopped with nonzero remaining ticks");

  // A drop sum needs at least one counted pair
  a_sum_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[TICKS_W+DSUM_W+DCNT_W-1:TICKS_W+DSUM_W] == '0)
      |-> m_tdata[TICKS_W+DSUM_W-1:TICKS_W] == '0)
    else $error("drop sum without counted pairs");

  // One transaction at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second input accepted while busy");

endmodule

bind drip_rate_remaining_time_top drt_checker u_drt_checker (.*);

FILE: verif/drt_estimate_checker.sv
// Scoreboard for the drip-rate remaining-time estimator.
// Watches the input, output and configuration channels, predicts each result
// and compares it field by field. Depends on drt_pkg.
module drt_estimate_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [drt_pkg::IN_TDATA_W-1:0]  s_tdata,   // weight[15:0]
  input  logic                            s_tuser,   // req_type
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // remaining_ticks[19:0], drop_sum[39:20], drop_count[43:40], pad[47:44]
  input  logic [drt_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            m_tuser,   // stopped
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [drt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drt_pkg::DATA_W-1:0]      cfg_data,
  output int                              outstanding,
  output int                              mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import drt_pkg::*;

  typedef struct packed {
    logic [TICKS_W-1:0] ticks;
    logic               stopped;
    logic [DSUM_W-1:0]  dsum;
    logic [DCNT_W-1:0]  dcnt;
  } drip_estimate_t;

  // Shadow of the block's registers and state
  logic [DATA_W-1:0]  empty_wt;
  logic [DATA_W-1:0]  max_wt;
  logic [DATA_W-1:0]  window [WINDOW_LEN];
  logic [TICKS_W-1:0] countdown;

  drip_estimate_t pending_estimates [$];

  // Advance the shadow state by one request and return the estimate it produces
  function automatic drip_estimate_t advance_estimator(input logic kind,
                                                       input logic [DATA_W-1:0] w);
    drip_estimate_t est;
    longint unsigned drops;
    longint unsigned quot;
    int pairs;
    drops = 0;
    pairs = 0;
    est = '0;
    if (kind == REQ_CLEAR) begin
      for (int i = 0; i < WINDOW_LEN; i++) window[i] = '0;
      countdown = '0;
    end else if (w > empty_wt && w < max_wt) begin
      // shift the newest sample in at the top
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] = window[i+1];
      window[WINDOW_LEN-1] = w;
      // accumulate every non-rising adjacent pair
      for (int i = 1; i < WINDOW_LEN; i++) begin
        if (window[i-1] >= window[i]) begin
          drops += longint'(window[i-1]) - longint'(window[i]);
          pairs++;
        end
      end
      if (pairs != 0 && drops != 0) begin
        quot = ((longint'(w) - longint'(empty_wt)) * longint'(pairs)) / drops;
        countdown = (quot > longint'(TICKS_MAX)) ? TICKS_MAX : quot[TICKS_W-1:0];
      end
    end else begin
      // out of range: count down, or report the countdown exhausted
      if (countdown != '0) countdown = countdown - 1'b1;
      else est.stopped = 1'b1;
    end
    est.ticks = countdown;
    est.dsum  = drops[DSUM_W-1:0];
    est.dcnt  = pairs[DCNT_W-1:0];
    return est;
  endfunction

  task automatic flag_result(input string why, input drip_estimate_t want,
                             input drip_estimate_t seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%t %s: exp t=%0d s=%0d sum=%0d n=%0d, got t=%0d s=%0d sum=%0d n=%0d",
               $realtime, why, want.ticks, want.stopped, want.dsum, want.dcnt,
               seen.ticks, seen.stopped, seen.dsum, seen.dcnt);
  endtask

  always @(posedge clk) begin
    drip_estimate_t seen;
    drip_estimate_t want;
    if (rst) begin
      empty_wt  = '0;
      max_wt    = '1;
      countdown = '0;
      for (int i = 0; i < WINDOW_LEN; i++) window[i] = '0;
      pending_estimates.delete();
    end else begin
      // compare a result transaction before any new prediction is queued
      if (m_tvalid && m_tready) begin
        seen.ticks   = m_tdata[TICKS_W-1:0];
        seen.dsum    = m_tdata[TICKS_W +: DSUM_W];
        seen.dcnt    = m_tdata[TICKS_W+DSUM_W +: DCNT_W];
        seen.stopped = m_tuser;
        if (pending_estimates.size() == 0) begin
          flag_result("unexpected result", '0, seen);
        end else begin
          want = pending_estimates.pop_front();
          if (seen !== want) flag_result("result mismatch", want, seen);
        end
      end
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EMPTY_WEIGHT: empty_wt = cfg_data;
          CFG_MAX_WEIGHT:   max_wt   = cfg_data;
          default: ;
        endcase
      end
      // predict each accepted request
      if (s_tvalid && s_tready)
        pending_estimates.push_back(advance_estimator(s_tuser, s_tdata[DATA_W-1:0]));
    end
    outstanding = pending_estimates.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the drip-rate remaining-time estimator.
// Generates requests, configuration writes and output backpressure; the
// drt_estimate_checker scoreboard predicts and compares. Depends on drt_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drt_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = WINDOW_LEN + NUM_W + 10;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data  = '0;

  int outstanding;
  int mismatch_count;
  bit calm = 1'b0;
  int ready_left = 0;

  drip_rate_remaining_time_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drt_estimate_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // Output backpressure: mostly ready, short stalls, an occasional long one
  always @(posedge clk) begin
    int roll;
    if (ready_left > 0) begin
      ready_left--;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        m_tready <= 1'b1;
        ready_left = $urandom_range(7, 0);
      end else if (roll < 92) begin
        m_tready <= 1'b0;
        ready_left = $urandom_range(3, 0);
      end else begin
        m_tready <= 1'b0;
        ready_left = $urandom_range(50, 10);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Weight at or below the empty weight, or at or above the maximum
  function automatic logic [DATA_W-1:0] pick_outside(input int lo, input int hi);
    if ($urandom_range(1)) return DATA_W'($urandom_range(lo, 0));
    return DATA_W'($urandom_range(65535, hi));
  endfunction

  task automatic send_item(input logic kind, input logic [DATA_W-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every expected result has arrived and the block is idle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int lo;
    int hi;
    int level;
    int step_max;
    int burst;
    int roll;
    int drift;
    bit has_range;
    logic kind;
    logic [DATA_W-1:0] w;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks at the reset settings
    send_item(REQ_SAMPLE, 16'h0000);  // below range with the countdown empty
    send_item(REQ_SAMPLE, 16'hFFFF);  // at the maximum weight
    send_item(REQ_CLEAR,  16'hFFFF);  // clear ignores the weight
    send_item(REQ_SAMPLE, 16'hFFFE);  // top of range, all-zero drop sum
    send_item(REQ_SAMPLE, 16'hFFFD);  // unit drop gives a very large estimate
    send_item(REQ_SAMPLE, 16'hFFFD);  // flat pair
    send_item(REQ_SAMPLE, 16'h0001);  // bottom of range, deep drop
    send_item(REQ_SAMPLE, 16'h9C40);  // rising sample
    repeat (3) send_item(REQ_SAMPLE, 16'h0000);
    send_item(REQ_CLEAR, 16'h0000);
    for (int k = 0; k < 6; k++) send_item(REQ_SAMPLE, DATA_W'(30000 - 5000 * k));
    // run the countdown down past zero
    repeat (4) send_item(REQ_SAMPLE, 16'hFFFF);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin lo = 0;     hi = 65535; end
        1: begin lo = 1000;  hi = 20000; end
        2: begin lo = 0;     hi = 0;     end
        3: begin lo = 65535; hi = 0;     end
        4: begin lo = 40000; hi = 40002; end
        5: begin lo = 0;     hi = 65535; end
        default: begin
          lo = $urandom_range(30000, 0);
          hi = $urandom_range(65535, lo + 2);
        end
      endcase
      drain();
      calm = (phase == 5);
      write_reg(CFG_EMPTY_WEIGHT, DATA_W'(lo));
      write_reg(CFG_MAX_WEIGHT, DATA_W'(hi));

      has_range = (hi > lo + 1);
      step_max  = $urandom_range(1) ? $urandom_range(40, 1) : $urandom_range(2000, 1);
      level     = lo;
      burst     = 0;

      repeat (ITEMS_PER_PHASE) begin
        kind = REQ_SAMPLE;
        roll = $urandom_range(99);
        if (burst > 0) begin
          burst--;
          w = pick_outside(lo, hi);
        end else if (roll < 4) begin
          kind = REQ_CLEAR;
          w = DATA_W'($urandom_range(65535, 0));
        end else if (roll < 7) begin
          // sensor off the hook for a while
          burst = $urandom_range(80, 1);
          w = pick_outside(lo, hi);
        end else if (roll < 15) begin
          w = pick_outside(lo, hi);
        end else if (roll < 27 || !has_range) begin
          w = DATA_W'($urandom_range(65535, 0));
        end else begin
          // steady drip: mostly falling, some flat samples and small rises
          drift = $urandom_range(99);
          if (level - lo <= step_max || level >= hi || drift < 3) begin
            level = $urandom_range(hi - 1, lo + 1);
          end else if (drift < 8) begin
            level = level + $urandom_range(step_max, 1);
            if (level > hi - 1) level = hi - 1;
          end else if (drift >= 18) begin
            level = level - $urandom_range(step_max, 1);
          end
          w = DATA_W'(level);
        end
        send_item(kind, w);
      end
    end

    drain();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
